FILE: rtl/otpa_pkg.sv
// Shared types and constants of the fp16 outer-product tile accumulator.
package otpa_pkg;

    localparam int TILE_COLS = 8;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

    // Item kinds
    localparam logic [1:0] KIND_PRELOAD = 2'd0;
    localparam logic [1:0] KIND_STEP    = 2'd1;
    localparam logic [1:0] KIND_FINISH  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ROWS_LOG2 = 1'b0;
    localparam logic CFG_ACC_MODE  = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  row;
        logic [63:0] lhs_lo;
        logic [63:0] lhs_hi;
        logic [63:0] rhs_lo;
        logic [63:0] rhs_hi;
        logic [63:0] acc_in_01;
        logic [63:0] acc_in_23;
        logic [63:0] acc_in_45;
        logic [63:0] acc_in_67;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  out_row;
        logic [63:0] out_cols_01;
        logic [63:0] out_cols_23;
        logic [63:0] out_cols_45;
        logic [63:0] out_cols_67;
        logic        last_row;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic       op_load;     // latch step operands
        logic       pre_wr;      // write preload row
        logic       rd_en;       // read accumulator row
        logic       step_rd;     // row read feeds the lanes
        logic [2:0] rd_row;
        logic       out_load;    // load output register from read data
        logic       out_last;
        logic       clear_vld;   // tile back to zero
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/f16_outer_product_tile_accumulator_top.sv
// Top level of the fp16 outer-product tile accumulator with fp32 accumulators.
//
// Input channel (i_in_valid/o_in_ready, payload i_in) takes three item kinds:
// preload writes one accumulator row (only when accumulate mode is set), step
// adds lhs[r]*rhs[c] into every active accumulator with one rounding to
// nearest even, finish emits the active rows on the output channel
// (o_out_valid/i_out_ready, payload o_out) and clears the tile to zero.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the
// user writes it only while the block is idle; the block does not enforce this.
// A step reads one row per cycle through eight six-stage fp32 multiply-add
// lanes: the transfer, the reads of the R active rows, then the lanes empty
// before the next item is taken. A finish reads each active row from the RAM,
// then loads it into the output register.
// After reset the tile is all zero, rows_log2 is 3 and accumulate mode is off.
// When the receiver stalls, the finished row waits in the output register and
// the next row read waits for it; a transfer frees the register at once.
module f16_outer_product_tile_accumulator_top import otpa_pkg::*; #(
    parameter int MAX_ROWS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;

    otpa_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind    (i_in.kind),
        .i_row     (i_in.row),
        .o_cmd     (cmd),
        .i_status  (status)
    );

    otpa_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

endmodule

FILE: rtl/otpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module otpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/otpa_fma_lane.sv
// One accumulator lane: fp16 x fp16 exact product added into fp32, six stages.
module otpa_fma_lane import otpa_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_acc,
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic [31:0] o_res
);

    function automatic logic [4:0] f_lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       done;
        n = 5'd24;
        done = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!done && v[i]) begin
                n = 5'(23 - i);
                done = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] f_lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       done;
        n = 5'd27;
        done = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!done && v[i]) begin
                n = 5'(26 - i);
                done = 1'b1;
            end
        end
        return n;
    endfunction

    // ---- stage 1: decode fp16 operands, exact product ----
    logic [4:0]  a_e, b_e, a_x, b_x;
    logic [10:0] a_s, b_s;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    always_comb begin
        a_e = i_a[14:10];
        b_e = i_b[14:10];
        a_s = {a_e != 5'd0, i_a[9:0]};
        b_s = {b_e != 5'd0, i_b[9:0]};
        a_x = (a_e == 5'd0) ? 5'd1 : a_e;
        b_x = (b_e == 5'd0) ? 5'd1 : b_e;
        a_nan = (a_e == 5'd31) && (i_a[9:0] != 10'd0);
        b_nan = (b_e == 5'd31) && (i_b[9:0] != 10'd0);
        a_inf = (a_e == 5'd31) && (i_a[9:0] == 10'd0);
        b_inf = (b_e == 5'd31) && (i_b[9:0] == 10'd0);
        a_zero = (i_a[14:0] == 15'd0);
        b_zero = (i_b[14:0] == 15'd0);
    end

    logic [21:0] r1_psig;
    logic [7:0]  r1_pexp;
    logic        r1_psgn, r1_pnan, r1_pinf;
    logic [31:0] r1_acc;

    always_ff @(posedge i_clk) begin
        r1_psig <= a_s * b_s;
        r1_pexp <= 8'({3'b0, a_x}) + 8'({3'b0, b_x}) + 8'd100;
        r1_psgn <= i_a[15] ^ i_b[15];
        r1_pnan <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
        r1_pinf <= a_inf | b_inf;
        r1_acc  <= i_acc;
    end

    // ---- stage 2: normalize product, decode accumulator, specials ----
    logic [4:0]  s2_lz;
    logic        s2_pzero, s2_anan, s2_ainf;
    logic [23:0] s2_pm;
    logic [7:0]  s2_pe, s2_ae;

    always_comb begin
        s2_pzero = (r1_psig == 22'd0);
        s2_lz = f_lzc24({2'b00, r1_psig});
        s2_pm = {2'b00, r1_psig} << s2_lz;
        s2_pe = s2_pzero ? 8'd1 : 8'(r1_pexp - {3'b0, s2_lz});
        s2_ae = (r1_acc[30:23] == 8'd0) ? 8'd1 : r1_acc[30:23];
        s2_anan = (r1_acc[30:23] == 8'hFF) && (r1_acc[22:0] != 23'd0);
        s2_ainf = (r1_acc[30:23] == 8'hFF) && (r1_acc[22:0] == 23'd0);
    end

    logic [23:0] r2_as, r2_ps;
    logic [7:0]  r2_ae, r2_pe;
    logic        r2_asgn, r2_psgn, r2_nan, r2_inf, r2_isgn;

    always_ff @(posedge i_clk) begin
        r2_as   <= {r1_acc[30:23] != 8'd0, r1_acc[22:0]};
        r2_ae   <= s2_ae;
        r2_asgn <= r1_acc[31];
        r2_ps   <= s2_pm;
        r2_pe   <= s2_pe;
        r2_psgn <= r1_psgn;
        r2_nan  <= s2_anan | r1_pnan
                 | (s2_ainf & r1_pinf & !r1_pnan & (r1_acc[31] != r1_psgn));
        r2_inf  <= s2_ainf | r1_pinf;
        r2_isgn <= s2_ainf ? r1_acc[31] : r1_psgn;
    end

    // ---- stage 3: order by magnitude, align smaller operand ----
    logic        s3_abig, s3_sticky;
    logic [23:0] s3_xs, s3_ys;
    logic [7:0]  s3_xe, s3_d;
    logic [26:0] s3_y27, s3_yal;

    always_comb begin
        s3_abig = {r2_ae, r2_as} >= {r2_pe, r2_ps};
        s3_xs = s3_abig ? r2_as : r2_ps;
        s3_ys = s3_abig ? r2_ps : r2_as;
        s3_xe = s3_abig ? r2_ae : r2_pe;
        s3_d  = s3_abig ? 8'(r2_ae - r2_pe) : 8'(r2_pe - r2_ae);
        s3_y27 = {s3_ys, 3'b000};
        if (s3_d > 8'd26) begin
            s3_yal = 27'd0;
            s3_sticky = (s3_ys != 24'd0);
        end else begin
            s3_yal = s3_y27 >> s3_d[4:0];
            s3_sticky = |(s3_y27 & ~({27{1'b1}} << s3_d[4:0]));
        end
    end

    logic [26:0] r3_x, r3_y;
    logic [7:0]  r3_e;
    logic        r3_sgn, r3_sub, r3_nan, r3_inf, r3_isgn;

    always_ff @(posedge i_clk) begin
        r3_x    <= {s3_xs, 3'b000};
        r3_y    <= s3_yal | {26'd0, s3_sticky};
        r3_e    <= s3_xe;
        r3_sgn  <= s3_abig ? r2_asgn : r2_psgn;
        r3_sub  <= r2_asgn ^ r2_psgn;
        r3_nan  <= r2_nan;
        r3_inf  <= r2_inf;
        r3_isgn <= r2_isgn;
    end

    // ---- stage 4: add or subtract magnitudes ----
    logic [27:0] r4_sum;
    logic [7:0]  r4_e;
    logic        r4_sgn, r4_sub, r4_nan, r4_inf, r4_isgn;

    always_ff @(posedge i_clk) begin
        r4_sum  <= r3_sub ? ({1'b0, r3_x} - {1'b0, r3_y}) : ({1'b0, r3_x} + {1'b0, r3_y});
        r4_e    <= r3_e;
        r4_sgn  <= r3_sgn;
        r4_sub  <= r3_sub;
        r4_nan  <= r3_nan;
        r4_inf  <= r3_inf;
        r4_isgn <= r3_isgn;
    end

    // ---- stage 5: normalize, stopping at the subnormal exponent ----
    logic [4:0]  s5_lz, s5_sh;
    logic [7:0]  s5_max;
    logic [26:0] s5_n;
    logic [8:0]  s5_e;

    always_comb begin
        s5_lz  = f_lzc27(r4_sum[26:0]);
        s5_max = r4_e - 8'd1;
        s5_sh  = ({3'b0, s5_lz} <= s5_max) ? s5_lz : s5_max[4:0];
        if (r4_sum[27]) begin
            s5_n = {r4_sum[27:2], r4_sum[1] | r4_sum[0]};
            s5_e = 9'({1'b0, r4_e}) + 9'd1;
        end else begin
            s5_n = r4_sum[26:0] << s5_sh;
            s5_e = 9'({1'b0, r4_e}) - 9'({4'd0, s5_sh});
        end
    end

    logic [26:0] r5_n;
    logic [8:0]  r5_e;
    logic        r5_sgn, r5_zero, r5_nan, r5_inf, r5_isgn;

    always_ff @(posedge i_clk) begin
        r5_n    <= s5_n;
        r5_e    <= s5_e;
        r5_zero <= (r4_sum == 28'd0);
        // exact cancellation gives +0
        r5_sgn  <= r4_sub ? ((r4_sum == 28'd0) ? 1'b0 : r4_sgn) : r4_sgn;
        r5_nan  <= r4_nan;
        r5_inf  <= r4_inf;
        r5_isgn <= r4_isgn;
    end

    // ---- stage 6: round to nearest even and pack ----
    logic [24:0] s6_mr;
    logic        s6_up;
    logic [8:0]  s6_field;
    logic [22:0] s6_frac;
    logic [31:0] s6_res;

    always_comb begin
        s6_up = r5_n[2] & (r5_n[1] | r5_n[0] | r5_n[3]);
        s6_mr = {1'b0, r5_n[26:3]} + {24'd0, s6_up};
        if (s6_mr[24]) begin
            s6_field = r5_e + 9'd1;
            s6_frac  = s6_mr[23:1];
        end else begin
            s6_field = s6_mr[23] ? r5_e : 9'd0;
            s6_frac  = s6_mr[22:0];
        end
        if (r5_nan) begin
            s6_res = QNAN_BITS;
        end else if (r5_inf) begin
            s6_res = {r5_isgn, 8'hFF, 23'd0};
        end else if (r5_zero) begin
            s6_res = {r5_sgn, 31'd0};
        end else if (s6_field >= 9'd255) begin
            s6_res = {r5_sgn, 8'hFF, 23'd0};
        end else begin
            s6_res = {r5_sgn, s6_field[7:0], s6_frac};
        end
    end

    logic [31:0] r6_res;

    always_ff @(posedge i_clk) begin
        r6_res <= s6_res;
    end

    assign o_res = r6_res;

endmodule

FILE: rtl/otpa_datapath.sv
// Datapath: accumulator RAM, row valid bits, eight lanes and output register.
module otpa_datapath import otpa_pkg::*; #(
    parameter int MAX_ROWS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LAT = 6;
    localparam int RW = 32 * TILE_COLS;

    logic [127:0]        r_lhs, r_rhs;
    logic [MAX_ROWS-1:0] r_vld;
    logic                r_v0, r_hit0;
    logic [2:0]          r_row0;
    logic [LAT:1]        r_vp;
    logic [2:0]          r_rowp [LAT:1];
    logic [RW-1:0]       rd_data, acc_row, lane_res, wr_data, pre_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    t_out_item           r_out;
    logic                r_out_valid;

    assign rd_addr  = i_cmd.rd_row[AW-1:0];
    assign pre_data = {i_in.acc_in_67, i_in.acc_in_45, i_in.acc_in_23, i_in.acc_in_01};

    // write port: preload from the input, otherwise lane results
    always_comb begin
        wr_en   = i_cmd.pre_wr | r_vp[LAT];
        wr_addr = i_cmd.pre_wr ? i_in.row[AW-1:0] : r_rowp[LAT][AW-1:0];
        wr_data = i_cmd.pre_wr ? pre_data : lane_res;
    end

    otpa_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_re   (i_cmd.rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // rows never written since the last finish read as zero
    assign acc_row = r_hit0 ? rd_data : '0;

    // step operands, read-row hit bit and row number pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.op_load) begin
            r_lhs <= {i_in.lhs_hi, i_in.lhs_lo};
            r_rhs <= {i_in.rhs_hi, i_in.rhs_lo};
        end
        r_hit0 <= r_vld[rd_addr];
        r_row0 <= i_cmd.rd_row;
        r_rowp[1] <= r_row0;
        for (int i = 2; i <= LAT; i++) begin
            r_rowp[i] <= r_rowp[i-1];
        end
    end

    // control: valid bits and lane pipeline occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_v0  <= 1'b0;
            r_vp  <= '0;
        end else begin
            r_v0 <= i_cmd.step_rd;
            r_vp <= {r_vp[LAT-1:1], r_v0};
            if (i_cmd.clear_vld) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    genvar c;
    generate
        for (c = 0; c < TILE_COLS; c++) begin : g_lane
            otpa_fma_lane u_lane (
                .i_clk(i_clk),
                .i_acc(acc_row[32*c +: 32]),
                .i_a  (r_lhs[16*r_row0 +: 16]),
                .i_b  (r_rhs[16*c +: 16]),
                .o_res(lane_res[32*c +: 32])
            );
        end
    endgenerate

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_row     <= r_row0;
            r_out.out_cols_01 <= acc_row[63:0];
            r_out.out_cols_23 <= acc_row[127:64];
            r_out.out_cols_45 <= acc_row[191:128];
            r_out.out_cols_67 <= acc_row[255:192];
            r_out.last_row    <= i_cmd.out_last;
        end
    end

    assign o_status.busy     = r_v0 | (|r_vp);
    assign o_status.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

endmodule

FILE: rtl/otpa_ctrl.sv
// Controller: configuration registers and the item sequencer.
module otpa_ctrl import otpa_pkg::*; #(
    parameter int MAX_ROWS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [2:0] i_row,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_DRAIN,
        S_FIN_RD,
        S_FIN_LD
    } t_state;

    t_state     r_state;
    logic [2:0] r_cnt;
    logic [1:0] r_rows_log2;
    logic       r_acc_mode;
    logic [3:0] rows_pow, rows;
    logic       accept, last;

    // active rows, limited to the tile height
    always_comb begin
        rows_pow = 4'd1 << r_rows_log2;
        rows     = (rows_pow > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : rows_pow;
        last     = ({1'b0, r_cnt} == rows - 4'd1);
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid & o_in_ready;

    // commands to the datapath
    always_comb begin
        o_cmd = '0;
        o_cmd.rd_row    = r_cnt;
        o_cmd.op_load   = accept & (i_kind == KIND_STEP);
        o_cmd.pre_wr    = accept & (i_kind == KIND_PRELOAD) & r_acc_mode
                        & ({1'b0, i_row} < 4'(MAX_ROWS));
        o_cmd.step_rd   = (r_state == S_STEP);
        o_cmd.rd_en     = (r_state == S_STEP)
                        | ((r_state == S_FIN_RD) & i_status.out_free);
        o_cmd.out_load  = (r_state == S_FIN_LD);
        o_cmd.out_last  = last;
        o_cmd.clear_vld = (r_state == S_FIN_LD) & last;
    end

    // state, counter and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 3'd0;
            r_rows_log2 <= 2'd3;
            r_acc_mode  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROWS_LOG2: r_rows_log2 <= i_cfg_data;
                    CFG_ACC_MODE:  r_acc_mode  <= i_cfg_data[0];
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= 3'd0;
                    if (accept && i_kind == KIND_STEP) begin
                        r_state <= S_STEP;
                    end else if (accept && i_kind == KIND_FINISH) begin
                        r_state <= S_FIN_RD;
                    end
                end
                S_STEP: begin
                    if (last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_DRAIN: begin
                    if (!i_status.busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_FIN_RD: begin
                    if (i_status.out_free) begin
                        r_state <= S_FIN_LD;
                    end
                end
                S_FIN_LD: begin
                    if (last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt   <= r_cnt + 3'd1;
                        r_state <= S_FIN_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
